// File: rtl/imu_dr_pkg.sv
package imu_dr_pkg;

    localparam int ACC_W     = 32;
    localparam int DT_W      = 20;
    localparam int STATE_W   = 64;
    localparam int PROD_W    = 84;
    localparam int REM_W     = 28;
    localparam int CNT_W     = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 384;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_DB  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VEL_DB    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_LIM  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WARMUP    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_NET_LIM   = 3'd4;

    localparam logic [30:0] RST_ACCEL_DB = 31'd1311;
    localparam logic [31:0] RST_VEL_DB   = 32'd429497;
    localparam logic [7:0]  RST_ZERO_LIM = 8'd3;
    localparam logic [15:0] RST_WARMUP   = 16'd100;
    localparam logic [30:0] RST_NET_LIM  = 31'd65536;

    // Divisors: dv = a*dt*1024/15625, vt = v*dt/1e6, at = a*dt*dt*8/244140625.
    localparam logic [REM_W-1:0] DIV_DV = 28'd15625;
    localparam logic [REM_W-1:0] DIV_VT = 28'd1000000;
    localparam logic [REM_W-1:0] DIV_AT = 28'd244140625;

    localparam logic [CNT_W-1:0] STEPS_DT  = 7'd20;
    localparam logic [CNT_W-1:0] STEPS_SQ  = 7'd32;
    localparam logic [CNT_W-1:0] STEPS_DIV = 7'd84;

    localparam logic [63:0] MAG_CAP = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

// File: rtl/imu_dead_reckoning_integrator.sv
// Processing: an accepted transaction runs four 32-step squarings, then per axis a 20-step
// multiply by dt and an 84-step restoring division for the velocity term and for the v*dt
// term, and two 20-step multiplies and one division for the dt^2 term, all on one bit-serial
// multiply/divide unit.
// A new item is not taken until the last one is through; the next item is taken while a result waits.
// Reset (synchronous, active low) clears the track, counters and output valid and loads the
// register defaults.
module imu_dead_reckoning_integrator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // acc_x, acc_y, acc_z, dt_us, zero fill
    input  logic [imu_dr_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    output logic [imu_dr_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // reset_fired
    output logic                                  o_m_tuser,
    input  logic                                  i_cfg_we,
    input  logic [imu_dr_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [imu_dr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import imu_dr_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_DIV, S_ACC, S_OUT} t_state;
    typedef enum logic [2:0] {OP_SQ, OP_DV, OP_VT, OP_AT1, OP_AT2} t_op;

    t_state r_state;
    t_op    r_op;
    logic [1:0]        r_ax;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_mx, r_prod, r_dvd;
    logic [31:0]       r_my;
    logic [REM_W-1:0]  r_rem;
    logic [63:0]       r_quo, r_mag, r_sum;
    logic              r_ovf, r_neg, r_fired;

    logic [30:0] r_adb, r_nlim;
    logic [31:0] r_vdb;
    logic [7:0]  r_zlim;
    logic [15:0] r_warm, r_sc;
    logic [DT_W-1:0] r_dt;

    logic signed [63:0] r_vel [3];
    logic signed [63:0] r_pos [3];
    logic [7:0]         r_zc  [3];
    logic [31:0]        r_am  [3];
    logic               r_aneg [3];

    // Deadband and zero-count handling, applied in the accept cycle.
    logic [31:0]        n_am   [3];
    logic               n_aneg [3];
    logic [7:0]         n_zc   [3];
    logic signed [63:0] n_vel  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [31:0]        a;
            logic signed [32:0] ax, db;
            logic signed [63:0] vdb;
            logic               a_small, v_small, zclr;
            logic [7:0]         zinc;
            a = i_s_tdata[32*i +: 32];
            ax = $signed({a[31], a});
            db = $signed({2'b00, r_adb});
            vdb = $signed({32'd0, r_vdb});
            a_small = (ax < db) && (ax > -db);
            v_small = (r_vel[i] < vdb) && (r_vel[i] > -vdb);
            zinc = (a_small && r_zc[i] != 8'hFF) ? r_zc[i] + 8'd1 : r_zc[i];
            zclr = zinc >= r_zlim;
            n_zc[i] = zclr ? 8'd0 : zinc;
            n_vel[i] = (v_small || zclr) ? 64'sd0 : r_vel[i];
            n_am[i] = a_small ? 32'd0 : (a[31] ? (~a + 32'd1) : a);
            n_aneg[i] = !a_small && a[31];
        end
    end

    logic accept;
    assign accept = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    logic [31:0] sq_val;
    always_comb begin
        case (r_ax)
            2'd0:    sq_val = r_am[0];
            2'd1:    sq_val = r_am[1];
            2'd2:    sq_val = r_am[2];
            default: sq_val = {1'b0, r_nlim};
        endcase
    end

    logic [REM_W-1:0] d_sel;
    always_comb begin
        case (r_op)
            OP_DV:   d_sel = DIV_DV;
            OP_VT:   d_sel = DIV_VT;
            default: d_sel = DIV_AT;
        endcase
    end

    // One restoring division step.
    logic [REM_W:0]   rem_sh;
    logic             q_bit;
    logic [REM_W-1:0] rem_nx;
    assign rem_sh = {r_rem, r_dvd[PROD_W-1]};
    assign q_bit  = rem_sh >= {1'b0, d_sel};
    assign rem_nx = q_bit ? REM_W'(rem_sh - {1'b0, d_sel}) : rem_sh[REM_W-1:0];

    // Round half up and clamp the magnitude to 2^63 (2^63-1 for a positive term).
    logic        rnd, big;
    logic [64:0] q_rnd;
    logic [63:0] mag_u, mag_fin;
    assign rnd   = {r_rem, 1'b0} >= {1'b0, d_sel};
    assign q_rnd = {1'b0, r_quo} + {64'd0, rnd};
    assign big   = r_ovf || (q_rnd > {1'b0, MAG_CAP});
    assign mag_u = big ? MAG_CAP : q_rnd[63:0];
    assign mag_fin = (!r_neg && mag_u[63]) ? POS_MAX : mag_u;

    // Saturating accumulate of the signed term.
    logic signed [63:0] acc_base, acc_sat;
    logic signed [65:0] acc_sum;
    assign acc_base = (r_op == OP_DV) ? r_vel[r_ax] : r_pos[r_ax];
    assign acc_sum  = r_neg ? ({{2{acc_base[63]}}, acc_base} - $signed({2'b00, r_mag}))
                            : ({{2{acc_base[63]}}, acc_base} + $signed({2'b00, r_mag}));
    always_comb begin
        if (acc_sum > $signed({2'b00, POS_MAX}))
            acc_sat = $signed(POS_MAX);
        else if (acc_sum < $signed({2'b11, MAG_CAP}))
            acc_sat = $signed(MAG_CAP);
        else
            acc_sat = acc_sum[63:0];
    end

    logic [63:0] vel_abs;
    assign vel_abs = r_vel[r_ax][63] ? (~r_vel[r_ax] + 64'd1) : r_vel[r_ax];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op <= OP_SQ;
            r_ax <= 2'd0;
            r_cnt <= '0;
            o_m_tvalid <= 1'b0;
            r_adb <= RST_ACCEL_DB;
            r_vdb <= RST_VEL_DB;
            r_zlim <= RST_ZERO_LIM;
            r_warm <= RST_WARMUP;
            r_nlim <= RST_NET_LIM;
            r_sc <= '0;
            for (int i = 0; i < 3; i++) begin
                r_vel[i] <= '0;
                r_pos[i] <= '0;
                r_zc[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ACCEL_DB: r_adb <= i_cfg_wdata[30:0];
                    CFG_VEL_DB:   r_vdb <= i_cfg_wdata;
                    CFG_ZERO_LIM: r_zlim <= i_cfg_wdata[7:0];
                    CFG_WARMUP:   r_warm <= i_cfg_wdata[15:0];
                    CFG_NET_LIM:  r_nlim <= i_cfg_wdata[30:0];
                    default: ;
                endcase
            end

            // In S_OUT the output register is handled by the state itself.
            if (o_m_tvalid && i_m_tready && r_state != S_OUT)
                o_m_tvalid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_dt <= i_s_tdata[96 +: DT_W];
                        for (int i = 0; i < 3; i++) begin
                            r_am[i] <= n_am[i];
                            r_aneg[i] <= n_aneg[i];
                            r_zc[i] <= n_zc[i];
                            r_vel[i] <= n_vel[i];
                        end
                        if (r_sc != 16'hFFFF)
                            r_sc <= r_sc + 16'd1;
                        r_fired <= 1'b0;
                        r_sum <= '0;
                        r_ax <= 2'd0;
                        r_op <= OP_SQ;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_prod <= '0;
                    r_cnt <= (r_op == OP_SQ) ? STEPS_SQ : STEPS_DT;
                    r_my <= (r_op == OP_SQ) ? sq_val : {12'd0, r_dt};
                    case (r_op)
                        OP_SQ:   r_mx <= {52'd0, sq_val};
                        OP_VT:   r_mx <= {20'd0, vel_abs};
                        default: r_mx <= {52'd0, r_am[r_ax]};
                    endcase
                    r_neg <= (r_op == OP_VT) ? r_vel[r_ax][63] : r_aneg[r_ax];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_cnt != '0) begin
                        if (r_my[0])
                            r_prod <= r_prod + r_mx;
                        r_mx <= {r_mx[PROD_W-2:0], 1'b0};
                        r_my <= {1'b0, r_my[31:1]};
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        case (r_op)
                            OP_SQ: begin
                                if (r_ax == 2'd3) begin
                                    // Net acceleration check after warm-up.
                                    if (r_sum > r_prod[63:0] && r_sc > r_warm) begin
                                        for (int i = 0; i < 3; i++) begin
                                            r_vel[i] <= '0;
                                            r_pos[i] <= '0;
                                        end
                                        r_sc <= '0;
                                        r_fired <= 1'b1;
                                    end
                                    r_ax <= 2'd0;
                                    r_op <= OP_DV;
                                end else begin
                                    r_sum <= r_sum + r_prod[63:0];
                                    r_ax <= r_ax + 2'd1;
                                end
                                r_state <= S_LOAD;
                            end
                            OP_AT1: begin
                                r_mx <= r_prod;
                                r_my <= {12'd0, r_dt};
                                r_prod <= '0;
                                r_cnt <= STEPS_DT;
                                r_op <= OP_AT2;
                            end
                            default: begin
                                case (r_op)
                                    OP_DV:   r_dvd <= {r_prod[PROD_W-11:0], 10'd0};
                                    OP_AT2:  r_dvd <= {r_prod[PROD_W-4:0], 3'd0};
                                    default: r_dvd <= r_prod;
                                endcase
                                r_rem <= '0;
                                r_quo <= '0;
                                r_ovf <= 1'b0;
                                r_cnt <= STEPS_DIV;
                                r_state <= S_DIV;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (r_cnt != '0) begin
                        r_rem <= rem_nx;
                        r_quo <= {r_quo[62:0], q_bit};
                        r_ovf <= r_ovf | r_quo[63];
                        r_dvd <= {r_dvd[PROD_W-2:0], 1'b0};
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_mag <= mag_fin;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_op == OP_DV)
                        r_vel[r_ax] <= acc_sat;
                    else
                        r_pos[r_ax] <= acc_sat;
                    case (r_op)
                        OP_DV: begin
                            r_op <= OP_VT;
                            r_state <= S_LOAD;
                        end
                        OP_VT: begin
                            r_op <= OP_AT1;
                            r_state <= S_LOAD;
                        end
                        default: begin
                            if (r_ax == 2'd2) begin
                                r_state <= S_OUT;
                            end else begin
                                r_ax <= r_ax + 2'd1;
                                r_op <= OP_DV;
                                r_state <= S_LOAD;
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    if (!o_m_tvalid || i_m_tready) begin
                        o_m_tdata <= {r_vel[2], r_vel[1], r_vel[0],
                                      r_pos[2], r_pos[1], r_pos[0]};
                        o_m_tuser <= r_fired;
                        o_m_tvalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/imu_dr_checker.sv
module imu_dr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic o_s_tready,
    input logic o_m_tvalid,
    input logic i_m_tready,
    input logic [imu_dr_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic o_m_tuser
);
    import imu_dr_pkg::*;

    // No result is pending right after reset.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // An accepted transaction keeps the input side busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready ##1 !o_s_tready)
        else $error("input accepted while an item is in progress");

    // With no result pending at an accept, no result appears in the cycle right after it.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("result appeared too early");

    // A stalled result holds its payload.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                          && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind imu_dead_reckoning_integrator imu_dr_checker u_imu_dr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
